// ----- rtl/tocf_pkg.sv -----
package tocf_pkg;

  localparam int POS_W      = 21;
  localparam int SPEED_W    = 14;
  localparam int HEAD_W     = 12;
  localparam int ACC_W      = 12;
  localparam int TIME_W     = 16;
  localparam int INTERVAL_W = 14;
  localparam int DIST_W     = 17;
  localparam int HTHR_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int SINE_FRACTION_BITS_DEFAULT = 15;

  localparam int FULL_TURN = 3600;
  localparam int QUARTER   = 900;
  localparam int ROM_LAST  = 900;

  // rounding divide by 1000 through a reciprocal, good for dividends below 2^29
  localparam int                DIV_K        = 1000;
  localparam int                ROUND_HALF   = 500;
  localparam int                RECIP_W      = 30;
  localparam int                RECIP_SHIFT  = 39;
  localparam logic [RECIP_W-1:0] RECIP_1000  = 30'd549755813;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISTANCE   = 3'd0,
    CFG_SPEED      = 3'd1,
    CFG_HEADING    = 3'd2,
    CFG_AGE        = 3'd3,
    CFG_DYNAMIC    = 3'd4,
    CFG_PREDICTION = 3'd5
  } cfg_reg_t;

  // sin(k * 0.1 deg) in Q(frac): Taylor series in Q30, each term truncated
  function automatic longint unsigned sine_entry(input int k, input int frac);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (longint'(k) * HALF_PI_Q30) / 900;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;   sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;   sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 210;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 272;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 342;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 420;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 506;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 600;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 702;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 812;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 930;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 1056; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 1190; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 1332; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 1482; sum = sum - longint'(term);
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) <<< 30)) sum = longint'(1) <<< 30;
    return longint'(unsigned'(sum + (longint'(1) <<< (29 - frac)))) >> (30 - frac);
  endfunction

endpackage

// ----- rtl/tracked_object_change_filter.sv -----
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------------
// in       | in_valid / in_ready        | has_history .. old_heading_dd
// out      | out_valid / out_ready      | include_now, include_next
// cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data (ready always high)
//
// One object per cycle; six register stages from input to output, the
// sine ROM read and the reciprocal divide-by-1000 steps set that depth.
// Synchronous reset clears the stage valid bits and loads the threshold
// defaults. A stalled output freezes every stage together, and in_ready
// drops for exactly those cycles.
module tracked_object_change_filter #(
  parameter int SINE_FRACTION_BITS = tocf_pkg::SINE_FRACTION_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tocf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tocf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 has_history,
  input  logic [tocf_pkg::TIME_W-1:0]          elapsed_ms,
  input  logic [tocf_pkg::INTERVAL_W-1:0]      until_next_ms,
  input  logic signed [tocf_pkg::POS_W-1:0]    pos_x_cm,
  input  logic signed [tocf_pkg::POS_W-1:0]    pos_y_cm,
  input  logic [tocf_pkg::SPEED_W-1:0]         speed_cms,
  input  logic [tocf_pkg::HEAD_W-1:0]          heading_dd,
  input  logic signed [tocf_pkg::ACC_W-1:0]    accel_cms2,
  input  logic signed [tocf_pkg::POS_W-1:0]    old_x_cm,
  input  logic signed [tocf_pkg::POS_W-1:0]    old_y_cm,
  input  logic [tocf_pkg::SPEED_W-1:0]         old_speed_cms,
  input  logic [tocf_pkg::HEAD_W-1:0]          old_heading_dd,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 include_now,
  output logic                                 include_next
);
  import tocf_pkg::*;

  localparam int RomW  = SINE_FRACTION_BITS + 1;
  localparam int AddrW = $clog2(ROM_LAST + 1);
  localparam int VtW   = SPEED_W + INTERVAL_W;
  localparam int AtW   = ACC_W + INTERVAL_W;
  localparam int MW    = RomW + VtW;
  localparam int NW    = VtW + 1;
  localparam int PW    = NW + RECIP_W;
  localparam int QW    = PW - RECIP_SHIFT;
  localparam int DlW   = QW + 1;
  localparam int DW    = POS_W + 1;
  localparam int PdW   = POS_W + 2;
  localparam int DvW   = SPEED_W + 1;
  localparam int PdvW  = DlW + 1;
  localparam int SqW   = 2 * DW;
  localparam int PsqW  = 2 * PdW;
  localparam int TsqW  = 2 * DIST_W;

  typedef logic [RomW-1:0] rom_t [0:ROM_LAST];
  typedef struct packed {
    logic             neg;
    logic [AddrW-1:0] addr;
  } rom_sel_t;

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= ROM_LAST; k++) begin
      r[k] = RomW'(sine_entry(k, SINE_FRACTION_BITS));
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  function automatic rom_sel_t rom_select(input logic [HEAD_W-1:0] a);
    rom_sel_t         s;
    logic [HEAD_W-1:0] r;
    if (a >= HEAD_W'(3 * QUARTER)) begin
      r = a - HEAD_W'(3 * QUARTER);
      s.addr = AddrW'(HEAD_W'(QUARTER) - r);
      s.neg  = 1'b1;
    end else if (a >= HEAD_W'(2 * QUARTER)) begin
      r = a - HEAD_W'(2 * QUARTER);
      s.addr = AddrW'(r);
      s.neg  = 1'b1;
    end else if (a >= HEAD_W'(QUARTER)) begin
      r = a - HEAD_W'(QUARTER);
      s.addr = AddrW'(HEAD_W'(QUARTER) - r);
      s.neg  = 1'b0;
    end else begin
      s.addr = AddrW'(a);
      s.neg  = 1'b0;
    end
    return s;
  endfunction

  // estimate is at most one low; one compare fixes it
  function automatic logic [QW-1:0] fix_quot(input logic [NW-1:0] n,
                                              input logic [PW-1:0] p);
    logic [QW-1:0] q;
    logic [NW:0]   rem;
    q   = p[PW-1:RECIP_SHIFT];
    rem = (NW+1)'(n) - (NW+1)'(q) * (NW+1)'(DIV_K);
    return (rem >= (NW+1)'(DIV_K)) ? q + QW'(1) : q;
  endfunction

  // configuration
  logic [DIST_W-1:0]     dist_thr;
  logic [SPEED_W-1:0]    speed_thr;
  logic [HTHR_W-1:0]     head_thr;
  logic [TIME_W-1:0]     age_thr;
  logic                  dyn_mode;
  logic [INTERVAL_W-1:0] pred_ms;
  logic [TsqW-1:0]       thr_sq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_thr  <= DIST_W'(400);
      speed_thr <= SPEED_W'(50);
      head_thr  <= HTHR_W'(40);
      age_thr   <= TIME_W'(1000);
      dyn_mode  <= 1'b0;
      pred_ms   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DISTANCE:   dist_thr  <= cfg_data[DIST_W-1:0];
        CFG_SPEED:      speed_thr <= cfg_data[SPEED_W-1:0];
        CFG_HEADING:    head_thr  <= cfg_data[HTHR_W-1:0];
        CFG_AGE:        age_thr   <= cfg_data[TIME_W-1:0];
        CFG_DYNAMIC:    dyn_mode  <= cfg_data[0];
        CFG_PREDICTION: pred_ms   <= cfg_data[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    thr_sq <= TsqW'(dist_thr) * TsqW'(dist_thr);
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: differences, heading, interval, products with the interval, ROM
  logic [HEAD_W-1:0]     ha, hb, hdiff, hcirc, hc;
  logic [HEAD_W:0]       hc_wide;
  logic [INTERVAL_W-1:0] t;
  rom_sel_t              sin_sel, cos_sel;

  always_comb begin
    ha = (heading_dd >= HEAD_W'(FULL_TURN)) ? heading_dd - HEAD_W'(FULL_TURN) : heading_dd;
    hb = (old_heading_dd >= HEAD_W'(FULL_TURN)) ?
         old_heading_dd - HEAD_W'(FULL_TURN) : old_heading_dd;
    hdiff = (ha > hb) ? ha - hb : hb - ha;
    hcirc = (HEAD_W'(FULL_TURN) - hdiff < hdiff) ? HEAD_W'(FULL_TURN) - hdiff : hdiff;
    hc_wide = {1'b0, ha} + (HEAD_W+1)'(QUARTER);
    hc = (hc_wide >= (HEAD_W+1)'(FULL_TURN)) ?
         HEAD_W'(hc_wide - (HEAD_W+1)'(FULL_TURN)) : HEAD_W'(hc_wide);
    sin_sel = rom_select(ha);
    cos_sel = rom_select(hc);
    if (pred_ms == '0) begin
      t = '0;
    end else if (dyn_mode) begin
      t = until_next_ms;
    end else begin
      t = pred_ms;
    end
  end

  logic                  s1_valid, s1_hist;
  logic signed [DW-1:0]  s1_dx, s1_dy;
  logic signed [DvW-1:0] s1_dv;
  logic [HEAD_W-1:0]     s1_hd;
  logic [TIME_W-1:0]     s1_elapsed;
  logic [INTERVAL_W-1:0] s1_t;
  logic [VtW-1:0]        s1_vt;
  logic signed [AtW-1:0] s1_at;
  logic [RomW-1:0]       s1_sin, s1_cos;
  logic                  s1_sin_neg, s1_cos_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_hist    <= has_history;
      s1_dx      <= DW'(pos_x_cm) - DW'(old_x_cm);
      s1_dy      <= DW'(pos_y_cm) - DW'(old_y_cm);
      s1_dv      <= $signed({1'b0, speed_cms}) - $signed({1'b0, old_speed_cms});
      s1_hd      <= hcirc;
      s1_elapsed <= elapsed_ms;
      s1_t       <= t;
      s1_vt      <= VtW'(speed_cms) * VtW'(t);
      s1_at      <= AtW'(accel_cms2) * $signed(AtW'(t));
      s1_sin     <= SineRom[sin_sel.addr];
      s1_cos     <= SineRom[cos_sel.addr];
      s1_sin_neg <= sin_sel.neg;
      s1_cos_neg <= cos_sel.neg;
    end
  end

  // stage 2: squares, projection products, threshold flags
  logic [DvW-2:0]  dv_abs;
  logic [AtW-1:0]  at_abs;
  logic [TIME_W:0] age_sum;
  logic [TIME_W-1:0] age_next;

  always_comb begin
    dv_abs   = (s1_dv < 0) ? (DvW-1)'(-s1_dv) : (DvW-1)'(s1_dv);
    at_abs   = (s1_at < 0) ? AtW'(-s1_at) : AtW'(s1_at);
    age_sum  = (TIME_W+1)'(s1_elapsed) + (TIME_W+1)'(s1_t);
    age_next = age_sum[TIME_W] ? '1 : age_sum[TIME_W-1:0];
  end

  logic                  s2_valid, s2_hist, s2_predict;
  logic                  s2_misc_exc, s2_hold_exc;
  logic [SqW-1:0]        s2_dx2, s2_dy2;
  logic [MW-1:0]         s2_mx, s2_my;
  logic [NW-1:0]         s2_nv;
  logic                  s2_x_neg, s2_y_neg, s2_v_neg;
  logic signed [DW-1:0]  s2_dx, s2_dy;
  logic signed [DvW-1:0] s2_dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_hist     <= s1_hist;
      s2_predict  <= (s1_t != '0);
      s2_misc_exc <= (dv_abs > speed_thr) || (s1_hd > HEAD_W'(head_thr)) ||
                     (s1_elapsed > age_thr);
      s2_hold_exc <= (s1_hd > HEAD_W'(head_thr)) || (age_next > age_thr);
      s2_dx2      <= SqW'(s1_dx) * SqW'(s1_dx);
      s2_dy2      <= SqW'(s1_dy) * SqW'(s1_dy);
      s2_mx       <= MW'(s1_sin) * MW'(s1_vt);
      s2_my       <= MW'(s1_cos) * MW'(s1_vt);
      s2_nv       <= NW'(at_abs) + NW'(ROUND_HALF);
      s2_x_neg    <= s1_sin_neg;
      s2_y_neg    <= s1_cos_neg;
      s2_v_neg    <= s1_at[AtW-1];
      s2_dx       <= s1_dx;
      s2_dy       <= s1_dy;
      s2_dv       <= s1_dv;
    end
  end

  // stage 3: current distance test, reciprocal products
  logic [SqW:0]  d2;
  logic [NW-1:0] nx, ny;

  always_comb begin
    d2 = (SqW+1)'(s2_dx2) + (SqW+1)'(s2_dy2);
    nx = NW'(s2_mx >> SINE_FRACTION_BITS) + NW'(ROUND_HALF);
    ny = NW'(s2_my >> SINE_FRACTION_BITS) + NW'(ROUND_HALF);
  end

  logic                  s3_valid, s3_now, s3_predict, s3_hold_exc;
  logic [NW-1:0]         s3_nx, s3_ny, s3_nv;
  logic [PW-1:0]         s3_px, s3_py, s3_pv;
  logic                  s3_x_neg, s3_y_neg, s3_v_neg;
  logic signed [DW-1:0]  s3_dx, s3_dy;
  logic signed [DvW-1:0] s3_dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_now      <= !s2_hist || s2_misc_exc || (d2 > (SqW+1)'(thr_sq));
      s3_predict  <= s2_predict;
      s3_hold_exc <= s2_hold_exc;
      s3_nx       <= nx;
      s3_ny       <= ny;
      s3_nv       <= s2_nv;
      s3_px       <= PW'(nx) * PW'(RECIP_1000);
      s3_py       <= PW'(ny) * PW'(RECIP_1000);
      s3_pv       <= PW'(s2_nv) * PW'(RECIP_1000);
      s3_x_neg    <= s2_x_neg;
      s3_y_neg    <= s2_y_neg;
      s3_v_neg    <= s2_v_neg;
      s3_dx       <= s2_dx;
      s3_dy       <= s2_dy;
      s3_dv       <= s2_dv;
    end
  end

  // stage 4: correct quotients, apply signs
  logic [QW-1:0] qx, qy, qv;

  always_comb begin
    qx = fix_quot(s3_nx, s3_px);
    qy = fix_quot(s3_ny, s3_py);
    qv = fix_quot(s3_nv, s3_pv);
  end

  logic                  s4_valid, s4_now, s4_predict, s4_hold_exc;
  logic signed [DlW-1:0] s4_dlx, s4_dly, s4_dlv;
  logic signed [DW-1:0]  s4_dx, s4_dy;
  logic signed [DvW-1:0] s4_dv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_now      <= s3_now;
      s4_predict  <= s3_predict;
      s4_hold_exc <= s3_hold_exc;
      s4_dlx      <= s3_x_neg ? -$signed(DlW'(qx)) : $signed(DlW'(qx));
      s4_dly      <= s3_y_neg ? -$signed(DlW'(qy)) : $signed(DlW'(qy));
      s4_dlv      <= s3_v_neg ? -$signed(DlW'(qv)) : $signed(DlW'(qv));
      s4_dx       <= s3_dx;
      s4_dy       <= s3_dy;
      s4_dv       <= s3_dv;
    end
  end

  // stage 5: projected differences, their squares, projected speed test
  logic signed [PdW-1:0]  pdx, pdy;
  logic signed [PdvW-1:0] pdv;
  logic [PdvW-1:0]        pdv_abs;

  always_comb begin
    pdx     = PdW'(s4_dx) + PdW'(s4_dlx);
    // y grows southward, so the cosine term subtracts
    pdy     = PdW'(s4_dy) - PdW'(s4_dly);
    pdv     = PdvW'(s4_dv) + PdvW'(s4_dlv);
    pdv_abs = (pdv < 0) ? PdvW'(-pdv) : PdvW'(pdv);
  end

  logic            s5_valid, s5_now, s5_predict, s5_hold_exc;
  logic [PsqW-1:0] s5_pdx2, s5_pdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_now      <= s4_now;
      s5_predict  <= s4_predict;
      s5_hold_exc <= s4_hold_exc || (pdv_abs > PdvW'(speed_thr));
      s5_pdx2     <= PsqW'(pdx) * PsqW'(pdx);
      s5_pdy2     <= PsqW'(pdy) * PsqW'(pdy);
    end
  end

  // stage 6: output register
  logic [PsqW:0] pd2;
  assign pd2 = (PsqW+1)'(s5_pdx2) + (PsqW+1)'(s5_pdy2);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      include_now  <= s5_now;
      include_next <= s5_predict && !s5_now &&
                      (s5_hold_exc || (pd2 > (PsqW+1)'(thr_sq)));
    end
  end

  a_now_next_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(include_now && include_next))
    else $error("include_now and include_next both set");

  a_no_history_included: assert property (@(posedge clk) disable iff (rst)
    en && s2_valid && !s2_hist |=> s3_valid && s3_now)
    else $error("object without history not included now");

  a_last_stage_reaches_output: assert property (@(posedge clk) disable iff (rst)
    en && s5_valid |=> out_valid)
    else $error("transaction lost between last stage and output");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tocf_pkg::*;

  typedef struct {
    logic                      hist;
    logic [TIME_W-1:0]         elapsed;
    logic [INTERVAL_W-1:0]     until_next;
    logic signed [POS_W-1:0]   x, y, ox, oy;
    logic [SPEED_W-1:0]        v, ov;
    logic [HEAD_W-1:0]         h, oh;
    logic signed [ACC_W-1:0]   acc;
  } object_t;

  localparam int FRAC = SINE_FRACTION_BITS_DEFAULT;
  localparam int STALL_LIMIT = 5000;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic include_now, include_next;
  object_t cur = '{default: '0};

  object_t pending_objects[$];
  logic [1:0] expected_flags[$];
  int sender_idle_pct = 0, receiver_stall_pct = 0;
  int fails = 0, quiet_cycles = 0;
  longint sine_table[0:900];

  // shadow register file
  longint dist_thr = 400, speed_thr = 50, head_thr = 40, age_thr = 1000;
  logic dyn_mode = 0;
  longint pred_ms = 0;

  tracked_object_change_filter uut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .has_history(cur.hist), .elapsed_ms(cur.elapsed), .until_next_ms(cur.until_next),
    .pos_x_cm(cur.x), .pos_y_cm(cur.y), .speed_cms(cur.v), .heading_dd(cur.h),
    .accel_cms2(cur.acc), .old_x_cm(cur.ox), .old_y_cm(cur.oy),
    .old_speed_cms(cur.ov), .old_heading_dd(cur.oh),
    .out_valid, .out_ready, .include_now, .include_next
  );

  initial forever #6 clk = ~clk;

  function automatic longint taylor_sine(int k);
    longint unsigned a, a2, term;
    longint acc_sum;
    a = (longint'(k) * 64'd1686629713) / 900;
    a2 = (a * a) >> 30;
    term = a;
    acc_sum = longint'(a);
    for (int n = 1; n < 20 && term != 0; n++) begin
      term = ((term * a2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2) acc_sum -= longint'(term);
      else acc_sum += longint'(term);
    end
    if (acc_sum < 0) acc_sum = 0;
    if (acc_sum > (longint'(1) << 30)) acc_sum = longint'(1) << 30;
    return (acc_sum + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
  endfunction

  function automatic longint sine_of(longint hd);
    longint q, r, s;
    hd = hd % FULL_TURN;
    q = hd / QUARTER;
    r = hd % QUARTER;
    s = (q % 2) ? sine_table[QUARTER - r] : sine_table[r];
    return (q >= 2) ? -s : s;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint m;
    m = (num < 0) ? -num : num;
    m = (m + den / 2) / den;
    return (num < 0) ? -m : m;
  endfunction

  function automatic bit over_threshold(longint x, longint y, longint v, longint h,
                                        longint age, object_t o);
    longint dx, dy, dv, hd, a, b;
    dx = x - o.ox;
    dy = y - o.oy;
    dv = v - longint'(o.ov);
    if (dv < 0) dv = -dv;
    a = h % FULL_TURN;
    b = longint'(o.oh) % FULL_TURN;
    hd = (a > b) ? a - b : b - a;
    if (FULL_TURN - hd < hd) hd = FULL_TURN - hd;
    return (dx * dx + dy * dy > dist_thr * dist_thr) || dv > speed_thr ||
           hd > head_thr || age > age_thr;
  endfunction

  // {include_now, include_next}
  function automatic logic [1:0] classify(object_t o);
    longint t, vt, px, py, pv, age;
    if (!o.hist) return 2'b10;
    if (over_threshold(o.x, o.y, o.v, o.h, o.elapsed, o)) return 2'b10;
    t = (pred_ms == 0) ? 0 : (dyn_mode ? longint'(o.until_next) : pred_ms);
    if (t == 0) return 2'b00;
    vt = longint'(o.v) * t;
    px = o.x + round_div(sine_of(o.h) * vt, longint'(1000) << FRAC);
    py = o.y - round_div(sine_of(longint'(o.h) + QUARTER) * vt, longint'(1000) << FRAC);
    pv = longint'(o.v) + round_div(longint'(o.acc) * t, 1000);
    age = longint'(o.elapsed) + t;
    if (age > 65535) age = 65535;
    return {1'b0, over_threshold(px, py, pv, o.h, age, o)};
  endfunction

  // sender: present the next object once the previous transaction is done
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_flags.push_back(classify(cur));
      if (pending_objects.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        cur <= pending_objects.pop_front();
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver: random stall, compare against the oldest expectation
  always @(posedge clk) begin
    logic [1:0] exp_f;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_flags.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result now=%0b next=%0b",
                                    include_now, include_next);
        end else begin
          exp_f = expected_flags.pop_front();
          if ({include_now, include_next} !== exp_f) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected now=%0b next=%0b, got now=%0b next=%0b",
                       exp_f[1], exp_f[0], include_now, include_next);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // watchdog: count busy cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_objects.size() == 0 && !in_valid && expected_flags.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(cfg_reg_t idx, longint val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      CFG_DISTANCE:   dist_thr = val & 'h1FFFF;
      CFG_SPEED:      speed_thr = val & 'h3FFF;
      CFG_HEADING:    head_thr = val & 'h7FF;
      CFG_AGE:        age_thr = val & 'hFFFF;
      CFG_DYNAMIC:    dyn_mode = val[0];
      CFG_PREDICTION: pred_ms = val & 'h3FFF;
      default: ;
    endcase
  endtask

  task automatic set_regs(longint d, longint s, longint hh, longint a, longint dm,
                          longint p);
    write_reg(CFG_DISTANCE, d);
    write_reg(CFG_SPEED, s);
    write_reg(CFG_HEADING, hh);
    write_reg(CFG_AGE, a);
    write_reg(CFG_DYNAMIC, dm);
    write_reg(CFG_PREDICTION, p);
  endtask

  task automatic drain();
    while (pending_objects.size() != 0 || in_valid || expected_flags.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic object_t random_object();
    object_t o;
    o.hist = $urandom;
    o.elapsed = $urandom;
    o.until_next = $urandom;
    o.x = $urandom;
    o.y = $urandom;
    o.v = $urandom;
    o.h = $urandom;
    o.acc = $urandom;
    o.ox = $urandom;
    o.oy = $urandom;
    o.ov = $urandom;
    o.oh = $urandom;
    return o;
  endfunction

  // an object close to its last record, so prediction gets exercised
  function automatic object_t near_object();
    object_t o;
    int span;
    o = random_object();
    span = $urandom_range(3) == 0 ? 2000 : 300;
    o.hist = 1;
    o.x = $urandom_range(2000000) - 1000000;
    o.y = $urandom_range(2000000) - 1000000;
    o.ox = o.x + $urandom_range(2 * span) - span;
    o.oy = o.y + $urandom_range(2 * span) - span;
    o.v = $urandom_range(3) == 0 ? $urandom_range(16383) : $urandom_range(3000);
    o.ov = o.v + $urandom_range(100) - 50;
    o.h = $urandom_range(3599);
    o.oh = (o.h + 3600 + $urandom_range(80) - 40) % 3600;
    o.elapsed = $urandom_range(1500);
    o.until_next = $urandom_range(3) == 0 ? 0 : $urandom_range(1500);
    o.acc = $urandom_range(3200) - 1600;
    return o;
  endfunction

  task automatic load_directed();
    object_t o;
    o = '{default: '0};
    pending_objects.push_back(o);                        // no history
    o.hist = 1;
    pending_objects.push_back(o);                        // identical record
    o.x = 400; pending_objects.push_back(o);             // distance at threshold
    o.x = 401; pending_objects.push_back(o);             // distance just over
    o.x = 0; o.v = 50; pending_objects.push_back(o);
    o.v = 51; pending_objects.push_back(o);
    o.v = 0; o.ov = 16383; pending_objects.push_back(o); // speed drop
    o.ov = 0; o.h = 3580; o.oh = 20; pending_objects.push_back(o); // wrap
    o.h = 3599; o.oh = 40; pending_objects.push_back(o);
    o.h = 4095; o.oh = 495; pending_objects.push_back(o); // out of range heading
    o.h = 0; o.oh = 0; o.elapsed = 1000; pending_objects.push_back(o);
    o.elapsed = 1001; pending_objects.push_back(o);
    o.elapsed = 65535; pending_objects.push_back(o);
    o.elapsed = 900; o.v = 16383; o.ov = 16383; o.h = 900; o.oh = 900;
    o.until_next = 0; pending_objects.push_back(o);
    o.until_next = 16383; o.acc = -2048; pending_objects.push_back(o);
    o.acc = 2047; o.h = 2700; o.oh = 2700; pending_objects.push_back(o);
    o.x = -1048576; o.y = 1048575; o.ox = -1048576; o.oy = 1048575;
    o.v = 10; o.ov = 10; o.h = 1800; o.oh = 1800; o.acc = 10; o.elapsed = 0;
    pending_objects.push_back(o);
    o.x = 1048575; o.y = -1048576; o.ox = 1048575; o.oy = -1048576;
    o.acc = -1600; o.until_next = 1; pending_objects.push_back(o);
  endtask

  task automatic run_random(int count);
    repeat (count) begin
      if ($urandom_range(99) < 70) pending_objects.push_back(near_object());
      else pending_objects.push_back(random_object());
    end
  endtask

  initial begin
    int idle_sender[4] = '{0, 69, 0, 24};
    int idle_receiver[4] = '{0, 0, 69, 24};
    for (int k = 0; k <= 900; k++) sine_table[k] = taylor_sine(k);
    repeat (2) @(posedge clk);
    rst <= 0;
    // defaults first, prediction off
    load_directed();
    run_random(60);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: set_regs(400, 50, 40, 1000, 0, 500);
        1: set_regs(0, 0, 0, 0, 0, 10000);
        2: set_regs(100000, 16383, 1800, 65535, 1, 16383);
        default: set_regs($urandom_range(3000), $urandom_range(200), $urandom_range(100),
                          $urandom_range(2000), $urandom_range(1), $urandom_range(3000));
      endcase
      sender_idle_pct = idle_sender[ph % 4];
      receiver_stall_pct = idle_receiver[(ph + ph / 4) % 4];
      if (ph == 2) load_directed();
      run_random(100);
      drain();
    end
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
